// ===== hw/rtl/mcvd_pkg.sv =====
`timescale 1ns / 1ps

package mcvd_pkg;

  localparam logic [31:0] CODE_HEAD      = 32'h4D56_6864;
  localparam logic [31:0] CODE_KEY       = 32'h4D56_304B;
  localparam logic [31:0] CODE_DELTA     = 32'h4D56_3046;
  localparam logic [31:0] HDR_LEN        = 32'h0000_0020;
  localparam logic [31:0] CHUNK_HEAD_LEN = 32'd8;

  // Header byte offsets
  localparam logic [31:0] OFS_MAGIC_END = 32'd3;
  localparam logic [31:0] OFS_SIZE_END  = 32'd7;
  localparam logic [4:0]  OFS_WIDTH     = 5'h0C;
  localparam logic [4:0]  OFS_HEIGHT    = 5'h0E;
  localparam logic [4:0]  OFS_COUNT     = 5'h10;
  localparam logic [4:0]  OFS_SCALE     = 5'h18;
  localparam logic [4:0]  OFS_BASE      = 5'h1C;
  localparam logic [31:0] OFS_HDR_LAST  = 32'h0000_001F;

  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_TOO_SMALL  = 2'd0,
    ERR_BAD_MAGIC  = 2'd1,
    ERR_HDR_SIZE   = 2'd2,
    ERR_CHUNK_SIZE = 2'd3
  } err_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        is_key;
    logic        last_in_packet;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] frame_total;
    logic [31:0] ticks_per_second;
    logic [31:0] ticks_per_frame;
    err_e        error_code;
  } result_t;

endpackage

// ===== hw/rtl/mcvd_parser.sv =====
`timescale 1ns / 1ps

module mcvd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 file_start_i,
  input  logic [31:0]          file_length_i,
  output mcvd_pkg::result_t    result_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_HSKIP  = 3'd1,
    PH_CHEAD  = 3'd2,
    PH_PAY    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERR    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [63:0] head_q, head_d;
  logic [31:0] rem_q, rem_d;
  logic        key_q, key_d;
  logic [31:0] hsize_q, hsize_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] count_q, count_d;
  logic [31:0] scale_q, scale_d;
  logic [31:0] base_q, base_d;

  // State as seen by this byte, after a possible restart
  phase_e      phase_c;
  logic [31:0] pos_c;
  logic [63:0] head_c;
  logic [31:0] rem_c;
  logic        key_c;
  logic [31:0] hsize_c;
  logic [15:0] width_c;
  logic [15:0] height_c;
  logic [31:0] count_c;
  logic [31:0] scale_c;
  logic [31:0] base_c;

  logic [63:0] head_sh;
  logic [31:0] le_size;
  logic [4:0]  pos5;
  logic [31:0] rem_dec;
  logic [31:0] rem_inc;
  logic [31:0] code;
  logic [32:0] chunk_end;
  logic [31:0] body_len;
  logic        is_key_code;
  logic        is_video;
  mcvd_pkg::result_t res;

  always_comb begin
    if (file_start_i) begin
      phase_c  = PH_HEADER;
      pos_c    = '0;
      head_c   = '0;
      rem_c    = '0;
      key_c    = 1'b0;
      hsize_c  = '0;
      width_c  = '0;
      height_c = '0;
      count_c  = '0;
      scale_c  = '0;
      base_c   = '0;
    end else begin
      phase_c  = phase_q;
      pos_c    = pos_q;
      head_c   = head_q;
      rem_c    = rem_q;
      key_c    = key_q;
      hsize_c  = hsize_q;
      width_c  = width_q;
      height_c = height_q;
      count_c  = count_q;
      scale_c  = scale_q;
      base_c   = base_q;
    end
  end

  assign head_sh     = {head_c[55:0], data_byte_i};
  // Little-endian size word from the four most recent bytes
  assign le_size     = {head_sh[7:0], head_sh[15:8], head_sh[23:16], head_sh[31:24]};
  assign pos5        = pos_c[4:0];
  assign rem_dec     = rem_c - 32'd1;
  assign rem_inc     = rem_c + 32'd1;
  assign code        = head_sh[63:32];
  assign chunk_end   = {1'b0, pos_c} - 33'd7 + {1'b0, le_size};
  assign body_len    = le_size - mcvd_pkg::CHUNK_HEAD_LEN;
  assign is_key_code = (code == mcvd_pkg::CODE_KEY);
  assign is_video    = is_key_code || (code == mcvd_pkg::CODE_DELTA);

  always_comb begin
    phase_d  = phase_c;
    pos_d    = pos_c + 32'd1;
    head_d   = head_c;
    rem_d    = rem_c;
    key_d    = key_c;
    hsize_d  = hsize_c;
    width_d  = width_c;
    height_d = height_c;
    count_d  = count_c;
    scale_d  = scale_c;
    base_d   = base_c;
    res      = '0;

    case (phase_c)
      PH_HEADER: begin
        if ((pos_c == '0) && (file_length_i < mcvd_pkg::HDR_LEN)) begin
          res.valid      = 1'b1;
          res.kind       = mcvd_pkg::KIND_ERROR;
          res.error_code = mcvd_pkg::ERR_TOO_SMALL;
          phase_d        = PH_ERR;
        end else if ((pos_c == mcvd_pkg::OFS_MAGIC_END) &&
                     (head_sh[31:0] != mcvd_pkg::CODE_HEAD)) begin
          head_d         = head_sh;
          res.valid      = 1'b1;
          res.kind       = mcvd_pkg::KIND_ERROR;
          res.error_code = mcvd_pkg::ERR_BAD_MAGIC;
          phase_d        = PH_ERR;
        end else if ((pos_c == mcvd_pkg::OFS_SIZE_END) &&
                     ((le_size < mcvd_pkg::HDR_LEN) || (le_size > file_length_i))) begin
          head_d         = head_sh;
          res.valid      = 1'b1;
          res.kind       = mcvd_pkg::KIND_ERROR;
          res.error_code = mcvd_pkg::ERR_HDR_SIZE;
          phase_d        = PH_ERR;
        end else begin
          head_d = head_sh;
          if (pos_c == mcvd_pkg::OFS_SIZE_END) begin
            hsize_d = le_size;
          end
          // Header offsets are all below 32, so the low five bits select the field.
          if (pos5 inside {[mcvd_pkg::OFS_WIDTH : mcvd_pkg::OFS_HEIGHT - 5'd1]}) begin
            width_d[{pos5[0], 3'b000} +: 8] = data_byte_i;
          end else if (pos5 inside {[mcvd_pkg::OFS_HEIGHT : mcvd_pkg::OFS_COUNT - 5'd1]}) begin
            height_d[{pos5[0], 3'b000} +: 8] = data_byte_i;
          end else if (pos5 inside {[mcvd_pkg::OFS_COUNT : mcvd_pkg::OFS_COUNT + 5'd3]}) begin
            count_d[{pos5[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (pos5 inside {[mcvd_pkg::OFS_SCALE : mcvd_pkg::OFS_BASE - 5'd1]}) begin
            scale_d[{pos5[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (pos5 inside {[mcvd_pkg::OFS_BASE : 5'h1F]}) begin
            base_d[{pos5[1:0], 3'b000} +: 8] = data_byte_i;
          end
          if (pos_c == mcvd_pkg::OFS_HDR_LAST) begin
            res.valid            = 1'b1;
            res.kind             = mcvd_pkg::KIND_HEADER;
            res.frame_width      = width_c;
            res.frame_height     = height_c;
            res.frame_total      = count_c;
            res.ticks_per_second = scale_c;
            res.ticks_per_frame  = {data_byte_i, base_c[23:0]};
            head_d               = '0;
            if (hsize_c > mcvd_pkg::HDR_LEN) begin
              rem_d   = hsize_c - mcvd_pkg::HDR_LEN;
              phase_d = PH_HSKIP;
            end else begin
              rem_d   = '0;
              phase_d = PH_CHEAD;
            end
          end
        end
      end

      PH_DONE, PH_ERR: begin
      end

      default: begin
        if (pos_c >= file_length_i) begin
          phase_d = PH_DONE;
        end else if ((phase_c == PH_HSKIP) || (phase_c == PH_SKIP)) begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_CHEAD;
          end
        end else if (phase_c == PH_PAY) begin
          rem_d              = rem_dec;
          res.valid          = 1'b1;
          res.kind           = mcvd_pkg::KIND_PAYLOAD;
          res.payload_byte   = data_byte_i;
          res.is_key         = key_c;
          res.last_in_packet = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_d = PH_CHEAD;
          end
        end else if ((rem_c == '0) &&
                     ((file_length_i - pos_c) < mcvd_pkg::CHUNK_HEAD_LEN)) begin
          // Short tail: not enough bytes left for another chunk head
          phase_d = PH_DONE;
        end else if (rem_inc < mcvd_pkg::CHUNK_HEAD_LEN) begin
          head_d = head_sh;
          rem_d  = rem_inc;
        end else begin
          head_d = '0;
          if ((le_size < mcvd_pkg::CHUNK_HEAD_LEN) ||
              (chunk_end > {1'b0, file_length_i})) begin
            rem_d          = rem_inc;
            res.valid      = 1'b1;
            res.kind       = mcvd_pkg::KIND_ERROR;
            res.error_code = mcvd_pkg::ERR_CHUNK_SIZE;
            phase_d        = PH_ERR;
          end else begin
            key_d = is_key_code;
            rem_d = body_len;
            if (is_video) begin
              if (body_len == '0) begin
                res.valid  = 1'b1;
                res.kind   = mcvd_pkg::KIND_EMPTY;
                res.is_key = is_key_code;
                phase_d    = PH_CHEAD;
              end else begin
                phase_d = PH_PAY;
              end
            end else begin
              phase_d = (body_len != '0) ? PH_SKIP : PH_CHEAD;
            end
          end
        end
      end
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      head_q   <= '0;
      rem_q    <= '0;
      key_q    <= 1'b0;
      hsize_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      count_q  <= '0;
      scale_q  <= '0;
      base_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      head_q   <= head_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      hsize_q  <= hsize_d;
      width_q  <= width_d;
      height_q <= height_d;
      count_q  <= count_d;
      scale_q  <= scale_d;
      base_q   <= base_d;
    end
  end

endmodule

// ===== hw/rtl/movie_chunk_video_deframer.sv =====
`timescale 1ns / 1ps

// Movie file deframer. Bytes of a movie file enter on the slave stream, one per request,
// with tuser marking the first byte of a new file. The 32-byte header is checked and
// reported once (kind 0); after it, payload bytes of keyframe and delta-frame chunks
// leave one per request (kind 1, tlast on the final byte of a packet), an empty video
// chunk gives a single kind 2 request, and any format fault gives one kind 3 request,
// after which the file is ignored until the next start. Set file_length on the
// configuration channel while the block is idle. One byte is taken every cycle while
// the master side keeps up; a byte passes an input register, the chunk parser, whose
// result is combinational, and an output register before its result is offered on the
// master side. While a result waits on the master side, the next byte is held in the
// input register and the slave side stalls.
module movie_chunk_video_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] file_start

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [23:8] frame_width, [39:24] frame_height, [71:40] frame_total,
  // [103:72] ticks_per_second, [135:104] ticks_per_frame, [137:136] error_code, rest zero
  output logic [mcvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [mcvd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] kind, [2] is_key
  output logic         m_axis_tlast    // last_in_packet
);

  logic [31:0]       file_length_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_start_q;
  logic              out_valid_q, out_valid_d;
  mcvd_pkg::result_t out_q;
  mcvd_pkg::result_t res;
  logic              advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (cfg_valid_i) begin
      file_length_q <= cfg_data_i;
    end
  end

  // The held byte moves on whenever the output register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  mcvd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_byte_i   (in_byte_q),
    .file_start_i  (in_start_q),
    .file_length_i (file_length_q),
    .result_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.error_code, out_q.ticks_per_frame,
                          out_q.ticks_per_second, out_q.frame_total,
                          out_q.frame_height, out_q.frame_width, out_q.payload_byte};
  assign m_axis_tuser  = {out_q.is_key, out_q.kind};
  assign m_axis_tlast  = out_q.last_in_packet;

  // Only a payload byte may close a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_q.kind == mcvd_pkg::KIND_PAYLOAD)
    else $error("tlast on a request that is not a payload byte");

  // Header values appear only with the header request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_q.kind != mcvd_pkg::KIND_HEADER) |->
      (out_q.frame_width == '0) && (out_q.ticks_per_frame == '0))
    else $error("header fields set on a non-header request");

  // A byte held in the input register is never dropped while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held input byte lost");

endmodule

// ===== tb/sv/mcvd_stream_checker.sv =====
`timescale 1ns / 1ps

module mcvd_stream_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [31:0]                      cfg_data_i,

  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [7:0]                       s_tdata_i,   // [7:0] data_byte
  input  logic                             s_tuser_i,   // [0] file_start

  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // [7:0] payload_byte, [23:8] frame_width, [39:24] frame_height, [71:40] frame_total,
  // [103:72] ticks_per_second, [135:104] ticks_per_frame, [137:136] error_code, rest zero
  input  logic [mcvd_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [mcvd_pkg::OUT_TUSER_W-1:0] m_tuser_i,   // [1:0] kind, [2] is_key
  input  logic                             m_tlast_i,   // last_in_packet

  output int                               fail_count_o,
  output int                               awaited_o,
  output int                               bytes_o,
  output int                               headers_o,
  output int                               payloads_o,
  output int                               empties_o,
  output int                               faults_o
);

  import mcvd_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_HDR_SKIP,
    ST_CHUNK_HEAD,
    ST_PAYLOAD,
    ST_SKIP,
    ST_DONE,
    ST_FAULT
  } parse_stage_e;

  // Shadow of the parser, updated on every accepted input request.
  logic [31:0]  file_len;
  logic [31:0]  offset;
  parse_stage_e stage;
  logic [63:0]  head_sr;
  logic [31:0]  remain;
  logic         key_chunk;
  logic [31:0]  hdr_size;
  logic [15:0]  width_acc;
  logic [15:0]  height_acc;
  logic [31:0]  count_acc;
  logic [31:0]  scale_acc;
  logic [31:0]  base_acc;

  result_t      awaited_results[$];
  result_t      predicted;
  result_t      oldest;
  result_t      got;
  logic         emit;

  function automatic void clear_parser();
    offset     = '0;
    stage      = ST_HEADER;
    head_sr    = '0;
    remain     = '0;
    key_chunk  = 1'b0;
    hdr_size   = '0;
    width_acc  = '0;
    height_acc = '0;
    count_acc  = '0;
    scale_acc  = '0;
    base_acc   = '0;
  endfunction

  function automatic logic [31:0] le32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic result_t fault(input err_e code);
    result_t r;
    r            = '0;
    r.valid      = 1'b1;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    stage        = ST_FAULT;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("kind %0d byte %02h key %0b last %0b size %0dx%0d frames %0d rate %0d/%0d err %0d",
                     r.kind, r.payload_byte, r.is_key, r.last_in_packet, r.frame_width,
                     r.frame_height, r.frame_total, r.ticks_per_second, r.ticks_per_frame,
                     r.error_code);
  endfunction

  task automatic parse_file_byte(input logic [7:0] b, input logic restart,
                                 output logic has_result, output result_t r);
    logic [31:0] pos;
    logic [31:0] hs;
    logic [31:0] size;
    logic [31:0] code;
    logic [63:0] chunk_end;
    r          = '0;
    r.valid    = 1'b1;
    has_result = 1'b0;
    if (restart) begin
      clear_parser();
    end
    pos    = offset;
    offset = offset + 32'd1;

    if (stage == ST_HEADER) begin
      if (pos == 0 && file_len < HDR_LEN) begin
        r = fault(ERR_TOO_SMALL);
        has_result = 1'b1;
        return;
      end
      head_sr = {head_sr[55:0], b};
      if (pos == OFS_MAGIC_END && head_sr[31:0] != CODE_HEAD) begin
        r = fault(ERR_BAD_MAGIC);
        has_result = 1'b1;
        return;
      end
      if (pos == OFS_SIZE_END) begin
        hs = le32(head_sr[31:0]);
        if (hs < HDR_LEN || hs > file_len) begin
          r = fault(ERR_HDR_SIZE);
          has_result = 1'b1;
          return;
        end
        hdr_size = hs;
      end
      if (pos >= OFS_WIDTH && pos < OFS_HEIGHT) begin
        width_acc = width_acc | (16'(b) << (8 * (pos - OFS_WIDTH)));
      end else if (pos >= OFS_HEIGHT && pos < OFS_COUNT) begin
        height_acc = height_acc | (16'(b) << (8 * (pos - OFS_HEIGHT)));
      end else if (pos >= OFS_COUNT && pos < OFS_COUNT + 4) begin
        count_acc = count_acc | (32'(b) << (8 * (pos - OFS_COUNT)));
      end else if (pos >= OFS_SCALE && pos < OFS_BASE) begin
        scale_acc = scale_acc | (32'(b) << (8 * (pos - OFS_SCALE)));
      end else if (pos >= OFS_BASE && pos <= OFS_HDR_LAST) begin
        base_acc = base_acc | (32'(b) << (8 * (pos - OFS_BASE)));
      end
      if (pos == OFS_HDR_LAST) begin
        r.kind             = KIND_HEADER;
        r.frame_width      = width_acc;
        r.frame_height     = height_acc;
        r.frame_total      = count_acc;
        r.ticks_per_second = scale_acc;
        r.ticks_per_frame  = base_acc;
        has_result         = 1'b1;
        head_sr            = '0;
        if (hdr_size > HDR_LEN) begin
          remain = hdr_size - HDR_LEN;
          stage  = ST_HDR_SKIP;
        end else begin
          remain = '0;
          stage  = ST_CHUNK_HEAD;
        end
      end
      return;
    end

    if (stage == ST_DONE || stage == ST_FAULT) begin
      return;
    end
    if (pos >= file_len) begin
      stage = ST_DONE;
      return;
    end

    case (stage)
      ST_HDR_SKIP, ST_SKIP: begin
        remain = remain - 32'd1;
        if (remain == 0) begin
          stage = ST_CHUNK_HEAD;
        end
      end
      ST_PAYLOAD: begin
        remain           = remain - 32'd1;
        r.kind           = KIND_PAYLOAD;
        r.payload_byte   = b;
        r.is_key         = key_chunk;
        r.last_in_packet = (remain == 0);
        has_result       = 1'b1;
        if (remain == 0) begin
          stage = ST_CHUNK_HEAD;
        end
      end
      default: begin
        // A tail too short for another chunk head ends the file.
        if (remain == 0 && file_len - pos < CHUNK_HEAD_LEN) begin
          stage = ST_DONE;
          return;
        end
        head_sr = {head_sr[55:0], b};
        remain  = remain + 32'd1;
        if (remain < CHUNK_HEAD_LEN) begin
          return;
        end
        code      = head_sr[63:32];
        size      = le32(head_sr[31:0]);
        chunk_end = {32'd0, pos} - 64'd7 + {32'd0, size};
        head_sr   = '0;
        if (size < CHUNK_HEAD_LEN || chunk_end > {32'd0, file_len}) begin
          r = fault(ERR_CHUNK_SIZE);
          has_result = 1'b1;
          return;
        end
        key_chunk = (code == CODE_KEY);
        remain    = size - CHUNK_HEAD_LEN;
        if (code == CODE_KEY || code == CODE_DELTA) begin
          if (remain == 0) begin
            r.kind     = KIND_EMPTY;
            r.is_key   = key_chunk;
            has_result = 1'b1;
            stage      = ST_CHUNK_HEAD;
          end else begin
            stage = ST_PAYLOAD;
          end
        end else begin
          stage = (remain != 0) ? ST_SKIP : ST_CHUNK_HEAD;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len = '0;
      clear_parser();
      awaited_results.delete();
      fail_count_o = 0;
      awaited_o    = 0;
      bytes_o      = 0;
      headers_o    = 0;
      payloads_o   = 0;
      empties_o    = 0;
      faults_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        file_len = cfg_data_i;
      end

      // Results are checked before this edge's input is predicted, so an output can
      // never be matched against the byte taken in the same cycle.
      if (m_tvalid_i && m_tready_i) begin
        got                  = '0;
        got.valid            = 1'b1;
        got.kind             = kind_e'(m_tuser_i[1:0]);
        got.is_key           = m_tuser_i[2];
        got.last_in_packet   = m_tlast_i;
        got.payload_byte     = m_tdata_i[7:0];
        got.frame_width      = m_tdata_i[23:8];
        got.frame_height     = m_tdata_i[39:24];
        got.frame_total      = m_tdata_i[71:40];
        got.ticks_per_second = m_tdata_i[103:72];
        got.ticks_per_frame  = m_tdata_i[135:104];
        got.error_code       = err_e'(m_tdata_i[137:136]);
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with nothing outstanding: %s", $time, show(got));
          end
        end else begin
          oldest = awaited_results.pop_front();
          case (oldest.kind)
            KIND_HEADER:  headers_o++;
            KIND_PAYLOAD: payloads_o++;
            KIND_EMPTY:   empties_o++;
            default:      faults_o++;
          endcase
          if (got !== oldest || m_tdata_i[mcvd_pkg::OUT_TDATA_W-1:138] !== '0) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch, expected %s", $time, show(oldest));
              $display("%0t:           received %s pad %h", $time, show(got),
                       m_tdata_i[mcvd_pkg::OUT_TDATA_W-1:138]);
            end
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        parse_file_byte(s_tdata_i, s_tuser_i, emit, predicted);
        bytes_o++;
        if (emit) begin
          awaited_results.push_back(predicted);
        end
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import mcvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BYTES   = 200;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [31:0]            cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  int fail_count;
  int awaited;
  int n_bytes;
  int n_headers;
  int n_payload;
  int n_empty;
  int n_faults;
  int idle_cycles;
  int random_sent;

  logic src_gaps   = 1'b0;
  logic snk_stalls = 1'b0;

  // Bytes of the next file(s) to stream: {file_start, data_byte}.
  logic [8:0] file_q[$];

  movie_chunk_video_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mcvd_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .awaited_o    (awaited),
    .bytes_o      (n_bytes),
    .headers_o    (n_headers),
    .payloads_o   (n_payload),
    .empties_o    (n_empty),
    .faults_o     (n_faults)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stalls come in bursts while enabled.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (snk_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic put_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      file_q.push_back({1'b0, v[8*i +: 8]});
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) file_q.push_back({1'b0, 8'($urandom)});
  endtask

  // Pushes the first 'keep' bytes of a 32-byte header; the first carries file_start.
  task automatic put_header(input logic [31:0] magic, input logic [31:0] hsize,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [31:0] frames, input logic [31:0] tps,
                            input logic [31:0] tpf, input int keep);
    logic [255:0] hdr;
    hdr = {tpf, tps, 32'($urandom), frames, h, w, 32'($urandom), hsize,
           magic[7:0], magic[15:8], magic[23:16], magic[31:24]};
    for (int i = 0; i < keep; i++) begin
      file_q.push_back({i == 0, hdr[8*i +: 8]});
    end
  endtask

  task automatic put_chunk(input logic [31:0] code, input logic [31:0] csize,
                           input int npay);
    for (int i = 3; i >= 0; i--) begin
      file_q.push_back({1'b0, code[8*i +: 8]});
    end
    put_le(csize, 4);
    put_noise(npay);
  endtask

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 5))
      0, 1:    return CODE_KEY;
      2, 3:    return CODE_DELTA;
      4:       return $urandom;
      default: return CODE_HEAD;
    endcase
  endfunction

  task automatic build_random_file(output logic [31:0] flen);
    int          mode;
    int          extra;
    int          npay;
    logic [31:0] hs;
    mode = $urandom_range(0, 11);
    flen = '0;
    if (mode <= 6) begin
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      put_header(CODE_HEAD, HDR_LEN + extra, 16'($urandom), 16'($urandom), $urandom,
                 $urandom, $urandom, 32);
      put_noise(extra);
      repeat ($urandom_range(1, 4)) begin
        npay = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        put_chunk(pick_code(), CHUNK_HEAD_LEN + npay, npay);
      end
      flen = file_q.size();
      case ($urandom_range(0, 4))
        0: begin
          // Short tail counted in the file length.
          extra = $urandom_range(1, 7);
          put_noise(extra);
          flen = flen + extra;
        end
        1: put_noise($urandom_range(1, 6));
        2: flen = flen - $urandom_range(1, 6);
        3: repeat ($urandom_range(1, 10)) file_q.delete(file_q.size() - 1);
        default: ;
      endcase
    end else if (mode == 7) begin
      put_header(CODE_HEAD, HDR_LEN, 16'($urandom), 16'($urandom), $urandom, $urandom,
                 $urandom, 32);
      put_chunk(CODE_DELTA, CHUNK_HEAD_LEN + 3, 3);
      put_chunk(pick_code(), ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom, 4);
      flen = file_q.size();
    end else if (mode == 8) begin
      flen = 64;
      put_header(CODE_HEAD ^ (32'd1 << $urandom_range(0, 31)), HDR_LEN, 0, 0, 0, 0, 0, 6);
    end else if (mode == 9) begin
      flen = $urandom_range(32, 200);
      hs   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : flen + $urandom_range(1, 999);
      put_header(CODE_HEAD, hs, 0, 0, 0, 0, 0, 10);
    end else if (mode == 10) begin
      flen = $urandom_range(0, 31);
      file_q.push_back({1'b1, 8'($urandom)});
      put_noise($urandom_range(0, 6));
    end else begin
      flen = $urandom;
      file_q.push_back({1'b1, 8'($urandom)});
      put_noise($urandom_range(3, 11));
    end
  endtask

  task automatic push_byte(input logic [8:0] item);
    if (src_gaps && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item[7:0];
    s_axis_tuser  <= item[8];
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Streams file_q. The length is only written once every expected result has left
  // and the two-stage pipeline has had time to empty.
  task automatic play_file(input logic [31:0] flen, input logic write_cfg);
    if (write_cfg) begin
      s_axis_tvalid <= 1'b0;
      while (awaited != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= flen;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
    end
    foreach (file_q[i]) begin
      push_byte(file_q[i]);
    end
    file_q.delete();
  endtask

  initial begin
    logic [31:0] flen;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni     = 1'b1;
    src_gaps   = 1'b1;
    snk_stalls = 1'b1;
    @(negedge clk_i);

    // Files too short for a header, the empty length included.
    file_q.push_back({1'b1, 8'h4D});
    put_noise(1);
    play_file(32'd0, 1'b1);
    file_q.push_back({1'b1, 8'hFF});
    play_file(32'd31, 1'b1);

    // Header faults: corrupt magic, size below the minimum, size beyond the file.
    put_header(CODE_HEAD ^ 32'h0000_0100, HDR_LEN, 0, 0, 0, 0, 0, 5);
    play_file(32'd64, 1'b1);
    put_header(CODE_HEAD, HDR_LEN - 1, 0, 0, 0, 0, 0, 8);
    play_file(32'd64, 1'b1);
    put_header(CODE_HEAD, 32'd41, 0, 0, 0, 0, 0, 8);
    play_file(32'd40, 1'b1);

    // Largest length: keyframe and delta payloads, empty packets of both kinds, a
    // skipped chunk, then a chunk too long for the file; the rest is ignored.
    put_header(CODE_HEAD, HDR_LEN, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'h0,
               32'hFFFF_FFFF, 32);
    put_chunk(CODE_KEY, 32'd11, 3);
    put_chunk(CODE_DELTA, 32'd8, 0);
    put_chunk(CODE_KEY, 32'd8, 0);
    put_chunk(CODE_HEAD, 32'd10, 2);
    put_chunk(CODE_DELTA, 32'd9, 1);
    put_chunk(CODE_KEY, 32'hFFFF_FFFF, 3);
    play_file(32'hFFFF_FFFF, 1'b1);

    // Padded header, one delta packet, a short tail and bytes past the end.
    put_header(CODE_HEAD, 32'd40, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32);
    put_noise(8);
    put_chunk(CODE_DELTA, 32'd10, 2);
    put_noise(7);
    play_file(32'd54, 1'b1);

    // Header size at its top value: everything after the header is skipped.
    put_header(CODE_HEAD, 32'hFFFF_FFFF, 16'h1234, 16'h5678, 32'd1, 32'd2, 32'd3, 32);
    put_noise(4);
    play_file(32'hFFFF_FFFF, 1'b1);

    // Random files; the last quarter runs without gaps or stalls.
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      src_gaps   = (random_sent < RANDOM_BYTES * 3 / 4) && ($urandom_range(0, 3) != 0);
      snk_stalls = (random_sent < RANDOM_BYTES * 3 / 4) && ($urandom_range(0, 3) != 0);
      build_random_file(flen);
      random_sent += file_q.size();
      play_file(flen, $urandom_range(0, 4) != 0);
    end

    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Streamed %0d bytes; checked %0d header reports and %0d payload bytes.",
             n_bytes, n_headers, n_payload);
    $display("Also checked %0d empty packets and %0d format faults; %0d mismatches.",
             n_empty, n_faults, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
